### design/tlbpl_pkg.sv
package tlbpl_pkg;

   localparam int VA_W         = 24;
   localparam int PA_W         = 16;
   localparam int PAGE_W       = 16;
   localparam int OFFSET_W     = 8;
   localparam int FRAME_W      = 8;
   localparam int TIME_W       = 32;
   localparam int CNT_W        = 32;
   localparam int PAGES_CFG_W  = 11;
   localparam int FRAMES_CFG_W = 9;
   localparam int SLOTS_CFG_W  = 5;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS  = 2'd2;

   localparam logic [PAGES_CFG_W-1:0]  PAGES_RESET  = 11'd1024;
   localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 9'd256;
   localparam logic [SLOTS_CFG_W-1:0]  SLOTS_RESET  = 5'd16;

   localparam int DEF_MAX_PAGES  = 1024;
   localparam int DEF_MAX_FRAMES = 256;
   localparam int DEF_MAX_TLB    = 16;

   // tlb scan modes
   localparam logic [1:0] TM_HIT  = 2'd0;
   localparam logic [1:0] TM_DROP = 2'd1;
   localparam logic [1:0] TM_VICT = 2'd2;

   typedef struct packed {
      logic       clear_step;
      logic       start;
      logic       tscan_start;
      logic [1:0] tmode;
      logic       tstep;
      logic       miss;
      logic       pg_take;
      logic       fscan_start;
      logic       fstep;
      logic       ev_clear;
      logic       load;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic reject;
      logic tdone;
      logic tmatch;
      logic fdone;
      logic fevict;
      logic present;
      logic rsp_busy;
   } status_type;

endpackage

### design/tlbpl_ctrl.sv
module tlbpl_ctrl
   import tlbpl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_TSCAN  = 4'd3;
   localparam logic [3:0] S_MISS   = 4'd4;
   localparam logic [3:0] S_PGWAIT = 4'd5;
   localparam logic [3:0] S_FSCAN  = 4'd6;
   localparam logic [3:0] S_EVCLR  = 4'd7;
   localparam logic [3:0] S_TDROP  = 4'd8;
   localparam logic [3:0] S_LOAD   = 4'd9;
   localparam logic [3:0] S_TVICT  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.tmode = TM_HIT;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.reject) begin
               state_in = S_DONE;
            end else begin
               cmd.tscan_start = 1'b1;
               cmd.tmode = TM_HIT;
               state_in = S_TSCAN;
            end
         end
         S_TSCAN: begin
            cmd.tstep = 1'b1;
            if (st.tdone) state_in = st.tmatch ? S_DONE : S_MISS;
         end
         S_MISS: begin
            cmd.miss = 1'b1;
            state_in = S_PGWAIT;
         end
         S_PGWAIT: begin
            cmd.pg_take = 1'b1;
            cmd.fscan_start = 1'b1;
            state_in = S_FSCAN;
         end
         S_FSCAN: begin
            cmd.fstep = 1'b1;
            if (st.fdone) begin
               if (st.present) begin
                  cmd.tscan_start = 1'b1;
                  cmd.tmode = TM_VICT;
                  state_in = S_TVICT;
               end else if (st.fevict) begin
                  state_in = S_EVCLR;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_EVCLR: begin
            cmd.ev_clear = 1'b1;
            cmd.tscan_start = 1'b1;
            cmd.tmode = TM_DROP;
            state_in = S_TDROP;
         end
         S_TDROP: begin
            cmd.tstep = 1'b1;
            if (st.tdone) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            cmd.tscan_start = 1'b1;
            cmd.tmode = TM_VICT;
            state_in = S_TVICT;
         end
         S_TVICT: begin
            cmd.tstep = 1'b1;
            if (st.tdone) state_in = S_DONE;
         end
         S_DONE: begin
            if (!st.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### design/tlbpl_dp.sv
module tlbpl_dp
   import tlbpl_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int MAX_TLB    = DEF_MAX_TLB
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              st,
   input  logic [VA_W-1:0]         req_virtual_address,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PA_W-1:0]         rsp_phys_addr,
   output logic                    rsp_tlb_hit,
   output logic                    rsp_page_fault,
   output logic                    rsp_evicted,
   output logic                    rsp_out_of_range,
   output logic [CNT_W-1:0]        rsp_access_total,
   output logic [CNT_W-1:0]        rsp_miss_total,
   output logic [CNT_W-1:0]        rsp_fault_total
);

   localparam int PAW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FCW = $clog2(MAX_FRAMES + 1);
   localparam int TAW = (MAX_TLB > 1) ? $clog2(MAX_TLB) : 1;
   localparam int TCW = $clog2(MAX_TLB + 1);
   localparam int OWN_W = PAGE_W + TIME_W;

   // configuration
   logic [PAGES_CFG_W-1:0]  pages_ff;
   logic [FRAMES_CFG_W-1:0] frames_ff;
   logic [SLOTS_CFG_W-1:0]  slots_ff;
   logic [FCW-1:0] frames_lim;
   logic [TCW-1:0] slots_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff  <= PAGES_RESET;
         frames_ff <= FRAMES_RESET;
         slots_ff  <= SLOTS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PAGES:  pages_ff  <= csr_write_data;
            CSR_FRAMES: frames_ff <= csr_write_data[FRAMES_CFG_W-1:0];
            CSR_SLOTS:  slots_ff  <= csr_write_data[SLOTS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frames_ff == '0) frames_lim = FCW'(1);
      else if (32'(frames_ff) > 32'(MAX_FRAMES)) frames_lim = FCW'(MAX_FRAMES);
      else frames_lim = FCW'(frames_ff);
      if (slots_ff == '0) slots_lim = TCW'(1);
      else if (32'(slots_ff) > 32'(MAX_TLB)) slots_lim = TCW'(MAX_TLB);
      else slots_lim = TCW'(slots_ff);
   end

   // item state
   logic [VA_W-1:0]    va_ff, va_in;
   logic               reject_ff, reject_in;
   logic               hit_ff, hit_in;
   logic               present_ff, present_in;
   logic               fault_ff, fault_in;
   logic               evict_ff, evict_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [FAW-1:0]     pick_ff, pick_in;
   logic [PAGE_W-1:0]  old_ff, old_in;
   logic [TIME_W-1:0]  clock_ff, clock_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic [CNT_W-1:0]   faults_ff, faults_in;

   logic [PAGE_W-1:0]  page;
   logic [PAGE_W-1:0]  req_page;
   assign page     = va_ff[VA_W-1:OFFSET_W];
   assign req_page = req_virtual_address[VA_W-1:OFFSET_W];

   // page table memory, cleared by a sweep after reset
   logic [FRAME_W:0]  pt_mem [MAX_PAGES];
   logic [FRAME_W:0]  pt_rdata_ff;
   logic [PAW-1:0]    clr_ff;
   logic              pt_we;
   logic [PAW-1:0]    pt_waddr;
   logic [FRAME_W:0]  pt_wdata;
   logic              old_in_range;

   assign old_in_range = (32'(old_ff) < 32'(MAX_PAGES));

   always_comb begin
      pt_we = 1'b0;
      pt_waddr = clr_ff;
      pt_wdata = '0;
      if (cmd.clear_step) begin
         pt_we = 1'b1;
      end else if (cmd.ev_clear) begin
         pt_we = old_in_range;
         pt_waddr = old_ff[PAW-1:0];
      end else if (cmd.load) begin
         pt_we = 1'b1;
         pt_waddr = page[PAW-1:0];
         pt_wdata = {1'b1, FRAME_W'(pick_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
      pt_rdata_ff <= pt_mem[page[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + PAW'(1);
   end

   // frame owner memory: page and time, valid bits in flops
   logic [OWN_W-1:0]      fo_mem [MAX_FRAMES];
   logic [OWN_W-1:0]      fo_rdata_ff;
   logic [MAX_FRAMES-1:0] fv_ff;
   logic [FCW-1:0]        fidx_ff, fidx_in;
   logic                  fchk_vld_ff, fchk_vld_in;
   logic [FAW-1:0]        fchk_idx_ff, fchk_idx_in;
   logic [FAW-1:0]        fo_raddr;
   logic [TIME_W-1:0]     fbest_t_ff, fbest_t_in;
   logic [FAW-1:0]        fbest_i_ff, fbest_i_in;
   logic [PAGE_W-1:0]     fbest_p_ff, fbest_p_in;
   logic                  f_v, f_last, f_match, f_free, f_better, f_done;
   logic [PAGE_W-1:0]     f_page;
   logic [TIME_W-1:0]     f_time;

   assign fo_raddr = fidx_ff[FAW-1:0];
   assign f_v      = fv_ff[fchk_idx_ff];
   assign f_page   = fo_rdata_ff[OWN_W-1:TIME_W];
   assign f_time   = fo_rdata_ff[TIME_W-1:0];
   assign f_last   = (FCW'(fchk_idx_ff) == frames_lim - FCW'(1));
   assign f_match  = f_v && (f_page == page);
   assign f_free   = !f_v;
   assign f_better = (fchk_idx_ff == '0) || (f_time < fbest_t_ff);
   assign f_done   = fchk_vld_ff && (present_ff ? (f_match || f_last) : (f_free || f_last));

   always_ff @(posedge clock) begin
      if (cmd.load) fo_mem[pick_ff] <= {page, clock_ff};
      else if (cmd.fstep && fchk_vld_ff && present_ff && f_match)
         fo_mem[fchk_idx_ff] <= {page, clock_ff};
      fo_rdata_ff <= fo_mem[fo_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) fv_ff <= '0;
      else if (cmd.load) fv_ff[pick_ff] <= 1'b1;
   end

   // tlb entries
   logic                tv_ff    [MAX_TLB];
   logic [PAGE_W-1:0]   tpage_ff [MAX_TLB];
   logic [FRAME_W-1:0]  tframe_ff[MAX_TLB];
   logic [TIME_W-1:0]   ttime_ff [MAX_TLB];
   logic [TAW-1:0]      tidx_ff, tidx_in;
   logic [1:0]          tmode_ff, tmode_in;
   logic [TIME_W-1:0]   tbest_t_ff, tbest_t_in;
   logic [TAW-1:0]      tbest_i_ff, tbest_i_in;
   logic                t_v, t_last, t_better, t_stop, t_done;
   logic [TAW-1:0]      t_slot;

   assign t_v      = tv_ff[tidx_ff];
   assign t_last   = (TCW'(tidx_ff) == slots_lim - TCW'(1));
   assign t_better = (tidx_ff == '0) || (ttime_ff[tidx_ff] < tbest_t_ff);
   assign t_done   = t_stop || t_last;
   assign t_slot   = (!t_v || t_better) ? tidx_ff : tbest_i_ff;

   always_comb begin
      case (tmode_ff)
         TM_HIT:  t_stop = t_v && (tpage_ff[tidx_ff] == page);
         TM_DROP: t_stop = t_v && (tpage_ff[tidx_ff] == old_ff);
         TM_VICT: t_stop = !t_v;
         default: t_stop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TLB; i++) tv_ff[i] <= 1'b0;
      end else if (cmd.tstep) begin
         case (tmode_ff)
            TM_HIT: begin
               if (t_stop) ttime_ff[tidx_ff] <= clock_ff;
            end
            TM_DROP: begin
               if (t_stop) tv_ff[tidx_ff] <= 1'b0;
            end
            TM_VICT: begin
               if (t_done) begin
                  tv_ff[t_slot]     <= 1'b1;
                  tpage_ff[t_slot]  <= page;
                  tframe_ff[t_slot] <= frame_ff;
                  ttime_ff[t_slot]  <= clock_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // scalar next state
   always_comb begin
      va_in = va_ff;
      reject_in = reject_ff;
      hit_in = hit_ff;
      present_in = present_ff;
      fault_in = fault_ff;
      evict_in = evict_ff;
      frame_in = frame_ff;
      pick_in = pick_ff;
      old_in = old_ff;
      clock_in = clock_ff;
      miss_in = miss_ff;
      faults_in = faults_ff;
      fidx_in = fidx_ff;
      fchk_vld_in = fchk_vld_ff;
      fchk_idx_in = fchk_idx_ff;
      fbest_t_in = fbest_t_ff;
      fbest_i_in = fbest_i_ff;
      fbest_p_in = fbest_p_ff;
      tidx_in = tidx_ff;
      tmode_in = tmode_ff;
      tbest_t_in = tbest_t_ff;
      tbest_i_in = tbest_i_ff;

      if (cmd.start) begin
         va_in = req_virtual_address;
         reject_in = (32'(req_page) >= 32'(pages_ff)) || (32'(req_page) >= 32'(MAX_PAGES));
         hit_in = 1'b0;
         present_in = 1'b0;
         fault_in = 1'b0;
         evict_in = 1'b0;
         frame_in = '0;
         clock_in = clock_ff + TIME_W'(1);
      end
      if (cmd.miss) miss_in = miss_ff + CNT_W'(1);
      if (cmd.pg_take) begin
         present_in = pt_rdata_ff[FRAME_W];
         if (pt_rdata_ff[FRAME_W]) begin
            frame_in = pt_rdata_ff[FRAME_W-1:0];
         end else begin
            fault_in = 1'b1;
            faults_in = faults_ff + CNT_W'(1);
         end
      end
      if (cmd.fscan_start) begin
         fidx_in = '0;
         fchk_vld_in = 1'b0;
      end
      if (cmd.fstep) begin
         if (fidx_ff < frames_lim) begin
            fidx_in = fidx_ff + FCW'(1);
            fchk_vld_in = 1'b1;
            fchk_idx_in = fidx_ff[FAW-1:0];
         end else begin
            fchk_vld_in = 1'b0;
         end
         if (fchk_vld_ff && !present_ff) begin
            if (f_done) begin
               fchk_vld_in = 1'b0;
               evict_in = !f_free;
               pick_in = (f_free || f_better) ? fchk_idx_ff : fbest_i_ff;
               old_in = f_better ? f_page : fbest_p_ff;
            end else if (f_better) begin
               fbest_t_in = f_time;
               fbest_i_in = fchk_idx_ff;
               fbest_p_in = f_page;
            end
         end else if (f_done) begin
            fchk_vld_in = 1'b0;
         end
      end
      if (cmd.load) frame_in = FRAME_W'(pick_ff);
      if (cmd.tscan_start) begin
         tidx_in = '0;
         tmode_in = cmd.tmode;
      end
      if (cmd.tstep) begin
         tidx_in = tidx_ff + TAW'(1);
         if (tmode_ff == TM_HIT && t_stop) begin
            hit_in = 1'b1;
            frame_in = tframe_ff[tidx_ff];
         end
         if (tmode_ff == TM_VICT && t_v && t_better) begin
            tbest_t_in = ttime_ff[tidx_ff];
            tbest_i_in = tidx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
         miss_ff <= '0;
         faults_ff <= '0;
         fchk_vld_ff <= 1'b0;
         reject_ff <= 1'b0;
         present_ff <= 1'b0;
         tmode_ff <= TM_HIT;
      end else begin
         clock_ff <= clock_in;
         miss_ff <= miss_in;
         faults_ff <= faults_in;
         fchk_vld_ff <= fchk_vld_in;
         reject_ff <= reject_in;
         present_ff <= present_in;
         tmode_ff <= tmode_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
      hit_ff <= hit_in;
      fault_ff <= fault_in;
      evict_ff <= evict_in;
      frame_ff <= frame_in;
      pick_ff <= pick_in;
      old_ff <= old_in;
      fidx_ff <= fidx_in;
      fchk_idx_ff <= fchk_idx_in;
      fbest_t_ff <= fbest_t_in;
      fbest_i_ff <= fbest_i_in;
      fbest_p_ff <= fbest_p_in;
      tidx_ff <= tidx_in;
      tbest_t_ff <= tbest_t_in;
      tbest_i_ff <= tbest_i_in;
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_phys_addr <= reject_ff ? '0 : {frame_ff, va_ff[OFFSET_W-1:0]};
         rsp_tlb_hit <= hit_ff;
         rsp_page_fault <= fault_ff;
         rsp_evicted <= evict_ff;
         rsp_out_of_range <= reject_ff;
         rsp_access_total <= clock_ff;
         rsp_miss_total <= miss_ff;
         rsp_fault_total <= faults_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign st.clear_done = (clr_ff == PAW'(MAX_PAGES - 1));
   assign st.reject     = reject_ff;
   assign st.tdone      = t_done;
   assign st.tmatch     = t_stop;
   assign st.fdone      = f_done;
   assign st.fevict     = !f_free;
   assign st.present    = present_ff;
   assign st.rsp_busy   = rsp_valid_ff && rsp_stall;

endmodule

### design/tlb_paging_lru_translator_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_virtual_address
// rsp     | out       | rsp_valid, rsp_stall | rsp_phys_addr .. rsp_fault_total
// csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// one item at a time; a rejected page skips all lookups, a tlb hit ends after the tlb scan
// a miss adds a page table read, a pipelined frame pass, a tlb drop pass on
// eviction and a tlb victim pass
// after reset the page table is swept with req_stall high
// a new item is taken while the previous result waits on rsp_stall
module tlb_paging_lru_translator_core
   import tlbpl_pkg::*;
#(
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int MAX_TLB    = DEF_MAX_TLB
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VA_W-1:0]       req_virtual_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PA_W-1:0]       rsp_phys_addr,
   output logic                  rsp_tlb_hit,
   output logic                  rsp_page_fault,
   output logic                  rsp_evicted,
   output logic                  rsp_out_of_range,
   output logic [CNT_W-1:0]      rsp_access_total,
   output logic [CNT_W-1:0]      rsp_miss_total,
   output logic [CNT_W-1:0]      rsp_fault_total,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type st;

   tlbpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tlbpl_dp #(
      .MAX_PAGES  (MAX_PAGES),
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_TLB    (MAX_TLB)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_virtual_address  (req_virtual_address),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted          (rsp_evicted),
      .rsp_out_of_range     (rsp_out_of_range),
      .rsp_access_total     (rsp_access_total),
      .rsp_miss_total       (rsp_miss_total),
      .rsp_fault_total      (rsp_fault_total)
   );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tlbpl_pkg::*;

   typedef struct packed {
      logic [PA_W-1:0]  pa;
      logic             hit;
      logic             fault;
      logic             ev;
      logic             oor;
      logic [CNT_W-1:0] acc;
      logic [CNT_W-1:0] miss;
      logic [CNT_W-1:0] flt;
   } xlat_type;

   typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [VA_W-1:0]           va;
      bit                        chk;
      xlat_type                  want;
      logic [PAGES_CFG_W-1:0]    pages;
      logic [FRAMES_CFG_W-1:0]   frames;
      logic [SLOTS_CFG_W-1:0]    slots;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VA_W-1:0]       req_virtual_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PA_W-1:0]       rsp_phys_addr;
   logic                  rsp_tlb_hit;
   logic                  rsp_page_fault;
   logic                  rsp_evicted;
   logic                  rsp_out_of_range;
   logic [CNT_W-1:0]      rsp_access_total;
   logic [CNT_W-1:0]      rsp_miss_total;
   logic [CNT_W-1:0]      rsp_fault_total;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tlb_paging_lru_translator_core DUT (.*);

   // shadow of the translator state
   bit                      pg_present [DEF_MAX_PAGES];
   logic [FRAME_W-1:0]      pg_frame   [DEF_MAX_PAGES];
   bit                      fr_valid   [DEF_MAX_FRAMES];
   logic [PAGE_W-1:0]       fr_page    [DEF_MAX_FRAMES];
   logic [TIME_W-1:0]       fr_time    [DEF_MAX_FRAMES];
   bit                      tl_valid   [DEF_MAX_TLB];
   logic [PAGE_W-1:0]       tl_page    [DEF_MAX_TLB];
   logic [FRAME_W-1:0]      tl_frame   [DEF_MAX_TLB];
   logic [TIME_W-1:0]       tl_time    [DEF_MAX_TLB];
   logic [TIME_W-1:0]       clk_now, miss_cnt, fault_cnt;
   logic [PAGES_CFG_W-1:0]  cfg_pages;
   logic [FRAMES_CFG_W-1:0] cfg_frames;
   logic [SLOTS_CFG_W-1:0]  cfg_slots;

   xlat_type     pending_xlat [$];
   int           errors;
   int           items_sent, hits_seen, faults_seen, evicts_seen, rejects_seen;
   bit           calm;
   bit           hold_ask;
   bit           hold_done;
   int           hold_cnt;
   int           stall_run;
   stim_row_type stim [$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int clamp_count(int v, int m);
      if (v == 0) return 1;
      return (v > m) ? m : v;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   task automatic translate(input logic [VA_W-1:0] va, output xlat_type r);
      logic [PAGE_W-1:0]  page;
      logic [PAGE_W-1:0]  old;
      logic [FRAME_W-1:0] frame;
      int frames, slots, limit, pick, slot;
      bit found;
      page   = va[23:8];
      frames = clamp_count(int'(cfg_frames), DEF_MAX_FRAMES);
      slots  = clamp_count(int'(cfg_slots), DEF_MAX_TLB);
      limit  = (int'(cfg_pages) > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(cfg_pages);
      frame  = '0;
      r      = '0;
      clk_now++;
      if (int'(page) >= limit) begin
         r.oor = 1'b1;
      end else begin
         for (int i = 0; i < slots; i++) begin
            if (tl_valid[i] && tl_page[i] == page) begin
               r.hit      = 1'b1;
               frame      = tl_frame[i];
               tl_time[i] = clk_now;
               break;
            end
         end
         if (!r.hit) begin
            miss_cnt++;
            if (pg_present[page]) begin
               frame = pg_frame[page];
               for (int i = 0; i < frames; i++) begin
                  if (fr_valid[i] && fr_page[i] == page) begin
                     fr_time[i] = clk_now;
                     break;
                  end
               end
            end else begin
               fault_cnt++;
               r.fault = 1'b1;
               pick    = 0;
               found   = 0;
               for (int i = 0; i < frames; i++) begin
                  if (!fr_valid[i]) begin
                     pick  = i;
                     found = 1;
                     break;
                  end
               end
               if (!found) begin
                  for (int i = 1; i < frames; i++)
                     if (fr_time[i] < fr_time[pick]) pick = i;
                  old = fr_page[pick];
                  if (int'(old) < DEF_MAX_PAGES) pg_present[old] = 0;
                  for (int i = 0; i < slots; i++) begin
                     if (tl_valid[i] && tl_page[i] == old) begin
                        tl_valid[i] = 0;
                        break;
                     end
                  end
                  fr_valid[pick] = 0;
                  r.ev = 1'b1;
               end
               pg_present[page] = 1;
               pg_frame[page]   = pick[7:0];
               fr_valid[pick]   = 1;
               fr_page[pick]    = page;
               fr_time[pick]    = clk_now;
               frame            = pick[7:0];
            end
            slot = -1;
            for (int i = 0; i < slots; i++) begin
               if (!tl_valid[i]) begin
                  slot = i;
                  break;
               end
            end
            if (slot < 0) begin
               slot = 0;
               for (int i = 1; i < slots; i++)
                  if (tl_time[i] < tl_time[slot]) slot = i;
            end
            tl_valid[slot] = 1;
            tl_page[slot]  = page;
            tl_frame[slot] = frame;
            tl_time[slot]  = clk_now;
         end
      end
      r.pa   = r.oor ? '0 : {frame, va[7:0]};
      r.acc  = clk_now;
      r.miss = miss_cnt;
      r.flt  = fault_cnt;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checking
   always @(posedge clock) begin
      xlat_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_xlat.size() == 0) begin
            report("unexpected item", rsp_access_total, 32'h0);
         end else begin
            w = pending_xlat.pop_front();
            if (rsp_phys_addr !== w.pa)
               report("phys_addr", 32'(rsp_phys_addr), 32'(w.pa));
            if (rsp_tlb_hit !== w.hit)
               report("tlb_hit", 32'(rsp_tlb_hit), 32'(w.hit));
            if (rsp_page_fault !== w.fault)
               report("page_fault", 32'(rsp_page_fault), 32'(w.fault));
            if (rsp_evicted !== w.ev)
               report("evicted", 32'(rsp_evicted), 32'(w.ev));
            if (rsp_out_of_range !== w.oor)
               report("out_of_range", 32'(rsp_out_of_range), 32'(w.oor));
            if (rsp_access_total !== w.acc)
               report("access_total", rsp_access_total, w.acc);
            if (rsp_miss_total !== w.miss)
               report("miss_total", rsp_miss_total, w.miss);
            if (rsp_fault_total !== w.flt)
               report("fault_total", rsp_fault_total, w.flt);
            hits_seen    += int'(w.hit);
            faults_seen  += int'(w.fault);
            evicts_seen  += int'(w.ev);
            rejects_seen += int'(w.oor);
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
         hold_done <= 0;
         stall_run <= 0;
      end else if (hold_ask && !hold_done) begin
         hold_done <= 1;
         hold_cnt  <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run <= gap_len();
      end
   end

   task automatic send_item(input logic [VA_W-1:0] va, input bit chk, input xlat_type want);
      xlat_type r;
      int       g;
      @(negedge clock);
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      translate(va, r);
      pending_xlat.push_back(chk ? want : r);
      items_sent++;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_xlat.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_regs(input logic [PAGES_CFG_W-1:0] p, input logic [FRAMES_CFG_W-1:0] f,
                             input logic [SLOTS_CFG_W-1:0] s);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PAGES;
      csr_write_data   <= p;
      @(negedge clock);
      csr_index        <= CSR_FRAMES;
      csr_write_data   <= CSR_DATA_W'(f);
      @(negedge clock);
      csr_index        <= CSR_SLOTS;
      csr_write_data   <= CSR_DATA_W'(s);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_pages  = p;
      cfg_frames = f;
      cfg_slots  = s;
   endtask

   function automatic stim_row_type item_row(logic [VA_W-1:0] va, bit chk, xlat_type want);
      stim_row_type s;
      s.kind   = ROW_ITEM;
      s.va     = va;
      s.chk    = chk;
      s.want   = want;
      s.pages  = '0;
      s.frames = '0;
      s.slots  = '0;
      return s;
   endfunction

   function automatic stim_row_type cfg_row(int p, int f, int s);
      stim_row_type c;
      c.kind   = ROW_CFG;
      c.va     = '0;
      c.chk    = 1'b0;
      c.want   = '0;
      c.pages  = PAGES_CFG_W'(p);
      c.frames = FRAMES_CFG_W'(f);
      c.slots  = SLOTS_CFG_W'(s);
      return c;
   endfunction

   function automatic logic [VA_W-1:0] pick_address(int span);
      if ($urandom_range(0, 9) == 0) return VA_W'($urandom());
      return {PAGE_W'($urandom_range(0, span)), OFFSET_W'($urandom())};
   endfunction

   initial begin
      xlat_type none;
      int p, f, s, n;
      none = '0;
      errors = 0;
      items_sent = 0;
      hits_seen = 0;
      faults_seen = 0;
      evicts_seen = 0;
      rejects_seen = 0;
      calm = 0;
      hold_ask = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_virtual_address = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PAGES;
      csr_write_data = '0;
      clk_now = 0;
      miss_cnt = 0;
      fault_cnt = 0;
      cfg_pages = PAGES_RESET;
      cfg_frames = FRAMES_RESET;
      cfg_slots = SLOTS_RESET;
      for (int i = 0; i < DEF_MAX_PAGES; i++) begin
         pg_present[i] = 0;
         pg_frame[i] = '0;
      end
      for (int i = 0; i < DEF_MAX_FRAMES; i++) begin
         fr_valid[i] = 0;
         fr_page[i] = '0;
         fr_time[i] = '0;
      end
      for (int i = 0; i < DEF_MAX_TLB; i++) begin
         tl_valid[i] = 0;
         tl_page[i] = '0;
         tl_frame[i] = '0;
         tl_time[i] = '0;
      end

      // first accesses from reset: fault, reject, hit, last page, first rejected page
      stim.push_back(item_row(24'h0000FF, 1, '{16'h00FF, 0, 1, 0, 0, 1, 1, 1}));
      stim.push_back(item_row(24'hFFFFFF, 1, '{16'h0000, 0, 0, 0, 1, 2, 1, 1}));
      stim.push_back(item_row(24'h000000, 1, '{16'h0000, 1, 0, 0, 0, 3, 1, 1}));
      stim.push_back(item_row(24'h03FFAB, 1, '{16'h01AB, 0, 1, 0, 0, 4, 2, 2}));
      stim.push_back(item_row(24'h040000, 1, '{16'h0000, 0, 0, 0, 1, 5, 2, 2}));
      // tiny sizes: lru eviction and tlb replacement
      stim.push_back(cfg_row(3, 2, 2));
      stim.push_back(item_row(24'h000011, 0, none));
      stim.push_back(item_row(24'h000122, 0, none));
      stim.push_back(item_row(24'h000233, 0, none));
      stim.push_back(item_row(24'h000044, 0, none));
      stim.push_back(item_row(24'h000155, 0, none));
      stim.push_back(item_row(24'h000300, 0, none));
      stim.push_back(item_row(24'h0002FF, 0, none));
      stim.push_back(item_row(24'h000066, 0, none));
      // zero counts: pages rejects all, frames and slots act as one
      stim.push_back(cfg_row(0, 0, 0));
      stim.push_back(item_row(24'h000010, 1, '{16'h0000, 0, 0, 0, 1, 14, 8, 8}));
      stim.push_back(cfg_row(5, 0, 0));
      stim.push_back(item_row(24'h000377, 0, none));
      stim.push_back(item_row(24'h000488, 0, none));
      stim.push_back(item_row(24'h000399, 0, none));
      // oversized values clamp to the maximum sizes
      stim.push_back(cfg_row(2047, 511, 31));
      stim.push_back(item_row(24'h000001, 0, none));
      stim.push_back(item_row(24'h0FFF00, 0, none));
      stim.push_back(item_row(24'h03FF5A, 0, none));
      stim.push_back(item_row(24'h0003A5, 0, none));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      calm = 1;
      foreach (stim[k]) begin
         if (stim[k].kind == ROW_CFG)
            write_regs(stim[k].pages, stim[k].frames, stim[k].slots);
         else
            send_item(stim[k].va, stim[k].chk, stim[k].want);
      end
      calm = 0;

      for (int ph = 0; ph < 13; ph++) begin
         case ($urandom_range(0, 5))
            0: p = 1;
            1: p = 1024;
            2: p = 2047;
            3: p = 0;
            default: p = $urandom_range(1, 40);
         endcase
         case ($urandom_range(0, 6))
            0: f = 1;
            1: f = 256;
            2: f = 0;
            3: f = 511;
            default: f = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 5))
            0: s = 1;
            1: s = 16;
            2: s = 0;
            3: s = 31;
            default: s = $urandom_range(1, 6);
         endcase
         if (ph == 0) begin
            p = 12;
            f = 4;
            s = 3;
         end
         write_regs(PAGES_CFG_W'(p), FRAMES_CFG_W'(f), SLOTS_CFG_W'(s));
         calm = (ph == 4);
         if (ph == 2) hold_ask = 1;
         // most addresses land near the accepted page range to keep the lru busy
         n = (p == 0 || p == 1 || p > 64) ? 40 : p + 3;
         for (int k = 0; k < 110; k++) begin
            if (ph == 6 && k == 55) drain();
            send_item(pick_address(n), 0, none);
         end
      end
      calm = 0;

      drain();
      repeat (400) @(negedge clock);
      $display("ran %0d accesses over many register settings, zero and oversized included",
               items_sent);
      $display("  %0d tlb hits, %0d faults, %0d evictions, %0d rejected pages",
               hits_seen, faults_seen, evicts_seen, rejects_seen);
      if (errors == 0 && pending_xlat.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #(12.0 * 4000000);
      $display("timeout with %0d items outstanding", pending_xlat.size());
      $display("testbench: errors");
      $finish;
   end

endmodule
